FILE: hdl/piecewise_linear_cycle_generator_macros.svh
// ----------------------------------------------------------------------------
// Piecewise linear cycle generator: assertion macros
// Concurrent checks that are compiled for simulation and vanish for synthesis.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_CYCLE_GENERATOR_MACROS_SVH
`define PIECEWISE_LINEAR_CYCLE_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
// The consequent holds in the same cycle as the antecedent.
`define PLCG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("plcg: same-cycle check failed");
// The consequent holds in the cycle after the antecedent.
`define PLCG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("plcg: next-cycle check failed");
`else
`define PLCG_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PLCG_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/plcg_pkg.sv
// ----------------------------------------------------------------------------
// plcg_pkg
// Types, widths and constants shared by the waveform generator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package plcg_pkg;

    localparam int TIME_W   = 20;
    localparam int LEVEL_W  = 16;
    localparam int SMOOTH_W = 18;
    localparam int PHASE_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;

    // Signed widths of the interpolation terms.
    localparam int SPAN_W = TIME_W + 1;
    localparam int DIFF_W = LEVEL_W + 1;
    localparam int PROD_W = SPAN_W + DIFF_W;
    localparam int QUO_W  = PROD_W - 1;
    localparam int SUM_W  = QUO_W + 2;

    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W = $clog2(DIV_STEPS);

    typedef logic [TIME_W-1:0]  t_time;
    typedef logic [LEVEL_W-1:0] t_level;

    localparam logic [CFG_IDX_W-1:0] CFG_END_TIME_1 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_TIME_2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END_TIME_3 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_TIME_4 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_1    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_2    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_3    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_4    = 3'd7;

    localparam t_time  RST_END_TIME_1 = 20'd3277;
    localparam t_time  RST_END_TIME_2 = 20'd655;
    localparam t_time  RST_END_TIME_3 = 20'd13107;
    localparam t_time  RST_END_TIME_4 = 20'd47186;
    localparam t_level RST_LEVEL_1    = 16'd328;
    localparam t_level RST_LEVEL_2    = 16'd29491;
    localparam t_level RST_LEVEL_3    = 16'd32768;
    localparam t_level RST_LEVEL_4    = 16'd3277;

    localparam logic [PHASE_W-1:0] PHASE_ONE  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_FOUR = 2'd3;

    localparam logic signed [SUM_W-1:0] SMOOTH_MAX = 39'sd131071;
    localparam logic signed [SUM_W-1:0] SMOOTH_MIN = -39'sd131072;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_SETUP,
        S_MUL,
        S_LOAD,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic accept;
        logic update;
        logic setup;
        logic mul;
        logic load_div;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic zero_span;
        logic out_free;
    } t_status;

endpackage

FILE: hdl/piecewise_linear_cycle_generator.sv
// ----------------------------------------------------------------------------
// piecewise_linear_cycle_generator
// Four-phase periodic waveform: phase sequencing on each tick and a linearly
// interpolated, saturated level between the configured breakpoints.
// ----------------------------------------------------------------------------
// Channel  | Direction | Handshake                  | Payload
// input    | in        | i_in_valid / o_in_stall    | i_tick
// output   | out       | o_out_valid / i_out_stall  | o_phase, o_discrete_level,
//          |           |                            | o_smooth_level
// config   | in        | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// A tick passes through update, setup, multiply, divider load, the restoring
// divider (one bit per cycle) and output load; a zero span skips the divider.
// The next tick can be taken in the cycle after the result is loaded.
// Reset is synchronous and restores the configuration defaults, phase one and
// zero time. A stalled result is held in the output register; the sequencer
// waits to load the next one until that register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "piecewise_linear_cycle_generator_macros.svh"

module piecewise_linear_cycle_generator
    import plcg_pkg::*;
#(
    parameter int TIME_STEP = 66
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_tick,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [PHASE_W-1:0]          o_phase,
    output logic [LEVEL_W-1:0]          o_discrete_level,
    output logic signed [SMOOTH_W-1:0]  o_smooth_level
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_busy;

    plcg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy)
    );

    plcg_dp #(
        .TIME_STEP (TIME_STEP)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_tick           (i_tick),
        .i_cmd            (w_cmd),
        .i_out_stall      (i_out_stall),
        .o_status         (w_status),
        .o_out_valid      (o_out_valid),
        .o_phase          (o_phase),
        .o_discrete_level (o_discrete_level),
        .o_smooth_level   (o_smooth_level)
    );

    assign o_in_stall = w_busy;

    // A transfer in is always followed by the state update.
    `PLCG_ASSERT_NXT(a_accept_then_update, i_clk, i_rst_n, w_cmd.accept, w_cmd.update)
    // The sequencer issues at most one command per cycle.
    `PLCG_ASSERT_IMP(a_cmd_onehot, i_clk, i_rst_n, 1'b1, $onehot0(w_cmd))
    // Loading a result always leaves a valid output.
    `PLCG_ASSERT_NXT(a_load_gives_valid, i_clk, i_rst_n, w_cmd.load_out, o_out_valid)
    // No input is taken while a tick is being worked on.
    `PLCG_ASSERT_IMP(a_busy_stalls, i_clk, i_rst_n, w_cmd.update || w_cmd.div_step, o_in_stall)

endmodule

FILE: hdl/plcg_ctrl.sv
// ----------------------------------------------------------------------------
// plcg_ctrl
// Sequencer: walks one tick through update, setup, multiply, divider load,
// divide (not for a zero span), output load; counts the divider iterations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plcg_ctrl
    import plcg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: n_state = S_SETUP;
            S_SETUP:  n_state = S_MUL;
            S_MUL:    n_state = S_LOAD;
            S_LOAD: begin
                n_count = CNT_W'(DIV_STEPS - 1);
                n_state = i_status.zero_span ? S_DONE : S_DIV;
            end
            S_DIV: begin
                n_count = r_count - 1'b1;
                if (r_count == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_busy       = 1'b0;
                o_cmd.accept = i_in_valid;
            end
            S_UPDATE: o_cmd.update   = 1'b1;
            S_SETUP:  o_cmd.setup    = 1'b1;
            S_MUL:    o_cmd.mul      = 1'b1;
            S_LOAD:   o_cmd.load_div = 1'b1;
            S_DIV:    o_cmd.div_step = 1'b1;
            S_DONE:   o_cmd.load_out = i_status.out_free;
            default:  o_busy         = 1'b1;
        endcase
    end

endmodule

FILE: hdl/plcg_dp.sv
// ----------------------------------------------------------------------------
// plcg_dp
// Datapath: configuration registers, phase and time state, interpolation
// terms, multiplier, restoring divider and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module plcg_dp
    import plcg_pkg::*;
#(
    parameter int TIME_STEP = 66
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_tick,
    input  t_cmd                         i_cmd,
    input  logic                         i_out_stall,
    output t_status                      o_status,
    output logic                         o_out_valid,
    output logic [PHASE_W-1:0]           o_phase,
    output logic [LEVEL_W-1:0]           o_discrete_level,
    output logic signed [SMOOTH_W-1:0]   o_smooth_level
);

    t_time  r_end_time [4];
    t_level r_level    [4];

    logic               r_tick;
    logic [PHASE_W-1:0] r_phase;
    t_time              r_elapsed;

    logic signed [SPAN_W-1:0] r_span, r_offset;
    logic signed [DIFF_W-1:0] r_diff;
    t_level                   r_v1, r_v2;
    logic                     r_zero_span;
    logic signed [PROD_W-1:0] r_prod;

    logic [QUO_W-1:0]  r_quo;
    t_time             r_rem, r_divisor;
    logic              r_neg;

    logic                        r_out_valid;
    logic [PHASE_W-1:0]          r_out_phase;
    t_level                      r_out_level;
    logic signed [SMOOTH_W-1:0]  r_out_smooth;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_end_time[0] <= RST_END_TIME_1;
            r_end_time[1] <= RST_END_TIME_2;
            r_end_time[2] <= RST_END_TIME_3;
            r_end_time[3] <= RST_END_TIME_4;
            r_level[0]    <= RST_LEVEL_1;
            r_level[1]    <= RST_LEVEL_2;
            r_level[2]    <= RST_LEVEL_3;
            r_level[3]    <= RST_LEVEL_4;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_END_TIME_1: r_end_time[0] <= i_cfg_data;
                CFG_END_TIME_2: r_end_time[1] <= i_cfg_data;
                CFG_END_TIME_3: r_end_time[2] <= i_cfg_data;
                CFG_END_TIME_4: r_end_time[3] <= i_cfg_data;
                CFG_LEVEL_1:    r_level[0]    <= i_cfg_data[LEVEL_W-1:0];
                CFG_LEVEL_2:    r_level[1]    <= i_cfg_data[LEVEL_W-1:0];
                CFG_LEVEL_3:    r_level[2]    <= i_cfg_data[LEVEL_W-1:0];
                CFG_LEVEL_4:    r_level[3]    <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------- phase and time update ----------------
    logic [TIME_W:0]    w_time_sum;
    t_time              w_time_sat;
    logic [PHASE_W-1:0] n_phase;
    t_time              n_elapsed;

    // The elapsed time saturates rather than wrapping.
    assign w_time_sum = {1'b0, r_elapsed} + (TIME_W + 1)'(TIME_STEP);
    assign w_time_sat = w_time_sum[TIME_W] ? '1 : w_time_sum[TIME_W-1:0];

    always_comb begin
        n_phase   = r_phase;
        n_elapsed = r_elapsed;
        if (r_tick) begin
            n_elapsed = w_time_sat;
            if (w_time_sat >= r_end_time[r_phase]) begin
                if (r_phase == PHASE_FOUR) begin
                    n_phase   = PHASE_ONE;
                    n_elapsed = '0;
                end else begin
                    n_phase = r_phase + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PHASE_ONE;
            r_elapsed <= '0;
        end else if (i_cmd.update) begin
            r_phase   <= n_phase;
            r_elapsed <= n_elapsed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tick <= i_tick;
        end
    end

    // ---------------- interpolation terms ----------------
    logic [PHASE_W-1:0] w_prev;
    t_time              w_t1, w_t2;
    t_level             w_v1, w_v2;

    assign w_prev = r_phase - 1'b1;
    assign w_t2   = r_end_time[r_phase];
    assign w_v2   = r_level[r_phase];
    assign w_t1   = (r_phase == PHASE_ONE) ? '0 : r_end_time[w_prev];
    assign w_v1   = (r_phase == PHASE_ONE) ? '0 : r_level[w_prev];

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_span      <= $signed({1'b0, w_t2}) - $signed({1'b0, w_t1});
            r_offset    <= $signed({1'b0, r_elapsed}) - $signed({1'b0, w_t1});
            r_diff      <= $signed({1'b0, w_v2}) - $signed({1'b0, w_v1});
            r_v1        <= w_v1;
            r_v2        <= w_v2;
            r_zero_span <= (w_t2 == w_t1);
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(r_diff * r_offset);
        end
    end

    // ---------------- restoring divider ----------------
    logic [PROD_W-1:0] w_prod_mag;
    logic [SPAN_W-1:0] w_span_mag;
    logic [TIME_W:0]   w_shifted;
    logic [TIME_W+1:0] w_trial;

    assign w_prod_mag = r_prod[PROD_W-1] ? (~r_prod + 1'b1) : r_prod;
    assign w_span_mag = r_span[SPAN_W-1] ? (~r_span + 1'b1) : r_span;
    assign w_shifted  = {r_rem, r_quo[QUO_W-1]};
    assign w_trial    = {1'b0, w_shifted} - {2'b00, r_divisor};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_div) begin
            r_quo     <= w_prod_mag[QUO_W-1:0];
            r_divisor <= w_span_mag[TIME_W-1:0];
            r_rem     <= '0;
            r_neg     <= r_prod[PROD_W-1] ^ r_span[SPAN_W-1];
        end else if (i_cmd.div_step) begin
            // The partial remainder stays below the divisor, so 20 bits hold it.
            if (!w_trial[TIME_W+1]) begin
                r_rem <= w_trial[TIME_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shifted[TIME_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    // ---------------- result and output register ----------------
    logic signed [SUM_W-1:0]    w_q, w_sq, w_total;
    logic signed [SMOOTH_W-1:0] w_smooth;

    assign w_q     = $signed({2'b00, r_quo});
    assign w_sq    = r_neg ? -w_q : w_q;
    assign w_total = w_sq + $signed(SUM_W'(r_v1));

    always_comb begin
        if (r_zero_span) begin
            w_smooth = $signed({2'b00, r_v2});
        end else if (w_total > SMOOTH_MAX) begin
            w_smooth = SMOOTH_MAX[SMOOTH_W-1:0];
        end else if (w_total < SMOOTH_MIN) begin
            w_smooth = SMOOTH_MIN[SMOOTH_W-1:0];
        end else begin
            w_smooth = w_total[SMOOTH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_phase  <= r_phase;
            r_out_level  <= r_v2;
            r_out_smooth <= w_smooth;
        end
    end

    assign o_status.zero_span = r_zero_span;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid      = r_out_valid;
    assign o_phase          = r_out_phase;
    assign o_discrete_level = r_out_level;
    assign o_smooth_level   = r_out_smooth;

endmodule
